[hw/rtl/hmt_pkg.sv]
// Shared types, constants and helpers of the homogeneous matrix transform.
package hmt_pkg;

  localparam int unsigned NCOL      = 4;
  localparam int unsigned NLANE     = 3;
  localparam int unsigned NREG      = 8;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned PROD_W    = 64;
  localparam int unsigned SUM_W     = 66;
  localparam int unsigned RES_W     = 50;
  localparam int unsigned REM_W     = RES_W + 1;
  localparam int unsigned QUO_W     = 32;
  localparam int unsigned DIV_STEPS = QUO_W;

  localparam logic signed [31:0]    S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0]    S32_MIN = 32'sh8000_0000;
  localparam logic signed [RES_W-1:0] Q_ONE = RES_W'(65536);
  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(32768);

  localparam logic [NREG-1:0][CFG_W-1:0] CFG_RST = {
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000
  };

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_WZERO,
    MODE_DIV
  } hmt_mode_e;

  typedef struct packed {
    logic              action;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } hmt_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic              w_zero;
    logic              saturated;
  } hmt_out_t;

  typedef logic [NREG-1:0][CFG_W-1:0] hmt_cfg_t;
  typedef logic signed [RES_W-1:0] hmt_res_t;

  typedef struct packed {
    logic              use_div;
    logic              neg;
    logic signed [31:0] byp;
    logic              byp_sat;
  } hmt_lane_t;

  typedef struct packed {
    logic                             w_zero;
    logic [RES_W-1:0]                 den;
    hmt_lane_t [NLANE-1:0]            lane;
    logic [NLANE-1:0][REM_W-1:0]      rem;
    logic [NLANE-1:0][QUO_W-1:0]      nq;
  } hmt_div_t;

  function automatic logic signed [31:0] mat_entry(input hmt_cfg_t cfg, input int c,
                                                   input int r);
    logic [2:0] idx;
    idx = 3'((c << 1) + (r >> 1));
    return (r & 1) != 0 ? cfg[idx][63:32] : cfg[idx][31:0];
  endfunction

  function automatic logic signed [31:0] sat32(input hmt_res_t v);
    if (v > RES_W'(S32_MAX)) return S32_MAX;
    if (v < RES_W'(S32_MIN)) return S32_MIN;
    return v[31:0];
  endfunction

  function automatic logic is_sat32(input hmt_res_t v);
    return (v > RES_W'(S32_MAX)) || (v < RES_W'(S32_MIN));
  endfunction

endpackage

[hw/rtl/hmt_dot.sv]
// Multiply and accumulate stages: four dot products of the item with the matrix columns.
module hmt_dot import hmt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  hmt_in_t            item_i,
  input  hmt_cfg_t           cfg_i,
  output logic               valid_o,
  output logic               point_o,
  output hmt_res_t [NCOL-1:0] res_o
);

  logic signed [31:0] xv [NLANE];
  assign xv[0] = item_i.in_x;
  assign xv[1] = item_i.in_y;
  assign xv[2] = item_i.in_z;

  logic [2:0] vld_q;
  logic [2:0] pnt_q;

  logic signed [PROD_W-1:0] prod_q [NCOL][NLANE];
  logic signed [31:0]       bias_q [NCOL];
  logic signed [SUM_W-1:0]  s01_q  [NCOL];
  logic signed [SUM_W-1:0]  s2b_q  [NCOL];
  hmt_res_t                 res_q  [NCOL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pnt_q <= {pnt_q[1:0], item_i.action};
      for (int c = 0; c < NCOL; c++) begin
        for (int r = 0; r < NLANE; r++) begin
          prod_q[c][r] <= PROD_W'(xv[r]) * PROD_W'(mat_entry(cfg_i, c, r));
        end
        bias_q[c] <= item_i.action ? mat_entry(cfg_i, c, 3) : 32'sd0;
        s01_q[c]  <= SUM_W'(prod_q[c][0]) + SUM_W'(prod_q[c][1]);
        s2b_q[c]  <= SUM_W'(prod_q[c][2]) + (SUM_W'(bias_q[c]) <<< 16) + RND_HALF;
        res_q[c]  <= RES_W'((s01_q[c] + s2b_q[c]) >>> 16);
      end
    end
  end

  assign valid_o = vld_q[2];
  assign point_o = pnt_q[2];
  always_comb begin
    for (int c = 0; c < NCOL; c++) begin
      res_o[c] = res_q[c];
    end
  end

endmodule

[hw/rtl/hmt_prep.sv]
// Classification of w, magnitudes, bypass values and divider setup over two stages.
module hmt_prep import hmt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic                point_i,
  input  hmt_res_t [NCOL-1:0] res_i,
  output logic                valid_o,
  output hmt_div_t            div_o
);

  logic [1:0]       vld_q;
  hmt_mode_e        mode_q;
  logic [RES_W-1:0] den_q;
  logic [RES_W-1:0] mag_q [NLANE];
  logic             neg_q [NLANE];
  logic signed [31:0] byp_q [NLANE];
  logic             bsat_q [NLANE];
  hmt_div_t         div_q;

  hmt_mode_e        mode_d;
  hmt_res_t         w;

  assign w = res_i[3];

  always_comb begin
    priority if (!point_i)    mode_d = MODE_PASS;
    else if (w == '0)         mode_d = MODE_WZERO;
    else if (w == Q_ONE)      mode_d = MODE_PASS;
    else                      mode_d = MODE_DIV;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode_q <= mode_d;
      den_q  <= w[RES_W-1] ? RES_W'(-w) : RES_W'(w);
      for (int i = 0; i < NLANE; i++) begin
        mag_q[i] <= res_i[i][RES_W-1] ? RES_W'(-res_i[i]) : RES_W'(res_i[i]);
        neg_q[i] <= res_i[i][RES_W-1] ^ w[RES_W-1];
        if (mode_d == MODE_WZERO) begin
          byp_q[i]  <= (res_i[i] > 0) ? S32_MAX : ((res_i[i] < 0) ? S32_MIN : 32'sd0);
          bsat_q[i] <= res_i[i] != '0;
        end else begin
          byp_q[i]  <= sat32(res_i[i]);
          bsat_q[i] <= is_sat32(res_i[i]);
        end
      end

      div_q.w_zero <= mode_q == MODE_WZERO;
      div_q.den    <= den_q;
      for (int i = 0; i < NLANE; i++) begin
        if (mode_q == MODE_DIV && ({16'b0, mag_q[i]} >= {den_q, 16'b0})) begin
          div_q.lane[i].use_div <= 1'b0;
          div_q.lane[i].byp     <= neg_q[i] ? S32_MIN : S32_MAX;
          div_q.lane[i].byp_sat <= 1'b1;
        end else begin
          div_q.lane[i].use_div <= mode_q == MODE_DIV;
          div_q.lane[i].byp     <= byp_q[i];
          div_q.lane[i].byp_sat <= bsat_q[i];
        end
        div_q.lane[i].neg <= neg_q[i];
        div_q.rem[i]      <= REM_W'(mag_q[i] >> 16);
        div_q.nq[i]       <= {mag_q[i][15:0], 16'b0};
      end
    end
  end

  assign valid_o = vld_q[1];
  assign div_o   = div_q;

endmodule

[hw/rtl/hmt_div.sv]
// Restoring divider, one quotient bit per stage for three lanes, with rounding and clamping.
module hmt_div import hmt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  hmt_div_t div_i,
  output logic     valid_o,
  output hmt_out_t item_o
);

  function automatic hmt_div_t div_step(input hmt_div_t s);
    hmt_div_t         n;
    logic [REM_W-1:0] rs;
    n = s;
    for (int i = 0; i < NLANE; i++) begin
      rs = {s.rem[i][REM_W-2:0], s.nq[i][QUO_W-1]};
      if (rs >= {1'b0, s.den}) begin
        n.rem[i] = rs - {1'b0, s.den};
        n.nq[i]  = {s.nq[i][QUO_W-2:0], 1'b1};
      end else begin
        n.rem[i] = rs;
        n.nq[i]  = {s.nq[i][QUO_W-2:0], 1'b0};
      end
    end
    return n;
  endfunction

  logic [DIV_STEPS-1:0] vld_q;
  hmt_div_t             st_q [DIV_STEPS];
  logic                 ovld_q;
  hmt_out_t             out_q;
  hmt_out_t             out_d;
  hmt_div_t             last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      ovld_q <= 1'b0;
    end else if (en_i) begin
      vld_q  <= {vld_q[DIV_STEPS-2:0], valid_i};
      ovld_q <= vld_q[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= div_step(div_i);
      for (int k = 1; k < DIV_STEPS; k++) begin
        st_q[k] <= div_step(st_q[k-1]);
      end
      out_q <= out_d;
    end
  end

  assign last = st_q[DIV_STEPS-1];

  always_comb begin
    logic [QUO_W:0]     q;
    logic signed [31:0] v [NLANE];
    logic [NLANE-1:0]   s;
    for (int i = 0; i < NLANE; i++) begin
      q = {1'b0, last.nq[i]} +
          (QUO_W+1)'({last.rem[i], 1'b0} >= {2'b0, last.den});
      if (!last.lane[i].use_div) begin
        v[i] = last.lane[i].byp;
        s[i] = last.lane[i].byp_sat;
      end else if (last.lane[i].neg) begin
        s[i] = q > (QUO_W+1)'(33'h0_8000_0000);
        v[i] = s[i] ? S32_MIN : 32'(-q);
      end else begin
        s[i] = q > (QUO_W+1)'(33'h0_7FFF_FFFF);
        v[i] = s[i] ? S32_MAX : q[31:0];
      end
    end
    out_d.out_x     = v[0];
    out_d.out_y     = v[1];
    out_d.out_z     = v[2];
    out_d.w_zero    = last.w_zero;
    out_d.saturated = |s;
  end

  assign valid_o = ovld_q;
  assign item_o  = out_q;

endmodule

[hw/rtl/hmt_outq.sv]
// Two-entry output queue that decouples the pipeline from the result consumer.
module hmt_outq import hmt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  hmt_out_t item_i,
  output logic     room_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output hmt_out_t out_item_o
);

  logic [1:0] cnt_q, cnt_d;
  hmt_out_t   head_q, head_d, tail_q, tail_d;
  logic       pop;

  assign pop = out_valid_o && out_ready_i;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    unique case (cnt_q)
      2'd0: begin
        if (push_i) head_d = item_i;
      end
      2'd1: begin
        if (pop) begin
          if (push_i) head_d = item_i;
        end else if (push_i) begin
          tail_d = item_i;
        end
      end
      2'd2: begin
        if (pop) begin
          head_d = tail_q;
          if (push_i) tail_d = item_i;
        end
      end
      default: begin
        head_d = head_q;
      end
    endcase
    cnt_d = cnt_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign room_o      = cnt_q < 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_item_o  = head_q;

endmodule

[hw/rtl/homogeneous_matrix_transform.sv]
// Top level of the 4x4 homogeneous vertex transform with perspective divide.
// Each item (x, y, z in signed Q16.16 and a point/direction selector) is multiplied by
// the configured 4x4 matrix and, for points whose w is neither zero nor exactly one,
// divided by w; results saturate to 32 bits. One item is accepted per cycle while the
// output queue has room. Most of the pipeline depth is in the restoring divider, which
// resolves one quotient bit per stage over 32 stages for all three components at once.
// The user must write matrix registers only while no items are in flight; the block
// itself does not enforce this.
module homogeneous_matrix_transform import hmt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hmt_in_t              in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output hmt_out_t             out_item_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  hmt_cfg_t            cfg_q;
  logic                en;
  logic                dot_valid, dot_point;
  hmt_res_t [NCOL-1:0] dot_res;
  logic                prep_valid;
  hmt_div_t            prep_div;
  logic                div_valid;
  hmt_out_t            div_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NREG))) begin
      cfg_q[cfg_idx_i[2:0]] <= cfg_data_i;
    end
  end

  assign in_ready_o = en;

  hmt_dot u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (in_item_i),
    .cfg_i   (cfg_q),
    .valid_o (dot_valid),
    .point_o (dot_point),
    .res_o   (dot_res)
  );

  hmt_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dot_valid),
    .point_i (dot_point),
    .res_i   (dot_res),
    .valid_o (prep_valid),
    .div_o   (prep_div)
  );

  hmt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (prep_valid),
    .div_i   (prep_div),
    .valid_o (div_valid),
    .item_o  (div_item)
  );

  hmt_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (div_valid && en),
    .item_i      (div_item),
    .room_o      (en),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

[hw/rtl/hmt_checker.sv]
// Port-level checks of the homogeneous matrix transform and their binding.
module hmt_checker import hmt_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input hmt_out_t             out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("Result item changed or dropped while stalled.");

  a_ready_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(out_ready_i) |-> in_ready_o)
    else $error("Input stalled although the output side was draining.");

  a_wzero_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.w_zero && out_item_o.out_x != 32'sd0 |->
      out_item_o.out_x == S32_MAX || out_item_o.out_x == S32_MIN)
    else $error("Zero w did not clamp a nonzero component.");

  a_wzero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.w_zero &&
      (out_item_o.out_x != 32'sd0 || out_item_o.out_y != 32'sd0 ||
       out_item_o.out_z != 32'sd0) |-> out_item_o.saturated)
    else $error("Zero w clamped a component without the saturated flag.");

endmodule

bind homogeneous_matrix_transform hmt_checker u_hmt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

[test/tb.sv]
// Testbench for the homogeneous matrix transform: random and directed vertices checked against a predictor.
`timescale 1ns / 100ps
module tb import hmt_pkg::*;;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  hmt_in_t              in_item_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  hmt_out_t             out_item_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  homogeneous_matrix_transform uut (.*);

  always #4 clk_i = ~clk_i;

  logic [CFG_W-1:0] matrix [NREG];
  hmt_in_t  pending_vertices [$];
  hmt_out_t expected_vertices [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit in_taken = 1'b0;

  function automatic longint col_entry(int c, int r);
    logic [63:0] word;
    word = matrix[c * 2 + r / 2];
    return (r % 2) ? longint'(signed'(word[63:32])) : longint'(signed'(word[31:0]));
  endfunction

  // Exact Q32.32 sum of products, rounded half up to Q16.16.
  function automatic logic signed [127:0] dot_column(longint v[4], int c);
    logic signed [127:0] acc;
    acc = 0;
    for (int r = 0; r < 4; r++) acc += 128'(v[r]) * 128'(col_entry(c, r));
    return (acc + 128'sd32768) >>> 16;
  endfunction

  function automatic logic signed [127:0] clamp32(logic signed [127:0] v, ref bit sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 128'sd2147483647;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return -128'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic signed [127:0] divide_by_w(logic signed [127:0] n,
                                                      logic signed [127:0] d, ref bit sat);
    logic [127:0] a, b, q, rem;
    bit neg;
    neg = (n < 0) != (d < 0);
    a = (n < 0) ? -n : n;
    b = (d < 0) ? -d : d;
    q = (a << 16) / b;
    rem = (a << 16) % b;
    if (2 * rem >= b) q++;
    return clamp32(neg ? -$signed(q) : $signed(q), sat);
  endfunction

  function automatic hmt_out_t transform_vertex(hmt_in_t it);
    longint v[4];
    logic signed [127:0] res[3];
    logic signed [127:0] w;
    bit sat;
    hmt_out_t o;
    sat = 1'b0;
    o = '0;
    v[0] = it.in_x;
    v[1] = it.in_y;
    v[2] = it.in_z;
    v[3] = it.action ? 65536 : 0;
    for (int i = 0; i < 3; i++) res[i] = dot_column(v, i);
    if (it.action) begin
      w = dot_column(v, 3);
      if (w == 0) begin
        o.w_zero = 1'b1;
        for (int i = 0; i < 3; i++) begin
          if (res[i] > 0) begin
            res[i] = 128'sd2147483647;
            sat = 1'b1;
          end else if (res[i] < 0) begin
            res[i] = -128'sd2147483648;
            sat = 1'b1;
          end
        end
      end else if (w != 65536) begin
        for (int i = 0; i < 3; i++) res[i] = divide_by_w(res[i], w, sat);
      end
    end
    for (int i = 0; i < 3; i++) res[i] = clamp32(res[i], sat);
    o.out_x = res[0][31:0];
    o.out_y = res[1][31:0];
    o.out_z = res[2][31:0];
    o.saturated = sat;
    return o;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pending_vertices.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item_i <= pending_vertices[0];
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_off_cycles <= hold_off_cycles - 1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        expected_vertices.push_back(transform_vertex(pending_vertices.pop_front()));
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_vertices.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_item_o);
        end else begin
          if (expected_vertices[0] !== out_item_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, actual %p", expected_vertices[0], out_item_o);
          end
          void'(expected_vertices.pop_front());
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(int idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_IDX_W'(idx);
    cfg_data_i <= data;
    if (idx < NREG) matrix[idx] = data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_vertices.size() == 0 && expected_vertices.size() == 0);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(8 * 65536)) - 4 * 65536);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] rand_pair();
    return {rand_q(), rand_q()};
  endfunction

  function automatic hmt_in_t rand_vertex();
    hmt_in_t it;
    it.action = $urandom_range(1);
    it.in_x = rand_q();
    it.in_y = rand_q();
    it.in_z = rand_q();
    return it;
  endfunction

  task automatic queue_vertex(bit act, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    hmt_in_t it;
    it.action = act;
    it.in_x = x;
    it.in_y = y;
    it.in_z = z;
    pending_vertices.push_back(it);
  endtask

  initial begin
    for (int i = 0; i < NREG; i++) matrix[i] = CFG_RST[i];
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 16;
    recv_idle_pct = 80;
    queue_vertex(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    queue_vertex(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_vertex(1'b1, 32'h0, 32'h0, 32'h0);
    queue_vertex(1'b0, 32'hFFFF_FFFF, 32'h1, 32'h8000);
    drain();

    // Perspective projection: w taken from z, covers divide, zero w and w of one.
    write_reg(6, 64'h0);
    write_reg(7, {32'h0, 32'h0001_0000});
    write_reg(8, 64'hDEAD_BEEF_DEAD_BEEF);
    queue_vertex(1'b1, 32'h0002_0000, 32'hFFFE_0000, 32'h0000_0000);
    queue_vertex(1'b1, 32'h0, 32'h0, 32'h0);
    queue_vertex(1'b1, 32'h0003_0000, 32'h0005_0000, 32'h0001_0000);
    queue_vertex(1'b1, 32'h0003_0000, 32'h0005_0000, 32'h0002_0000);
    queue_vertex(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    queue_vertex(1'b1, 32'h0001_0000, 32'h0001_0000, 32'hFFFD_0000);
    queue_vertex(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    for (int i = 0; i < 140; i++) pending_vertices.push_back(rand_vertex());
    drain();

    for (int i = 0; i < NREG; i++) write_reg(i, {32'h8000_0000, 32'h7FFF_FFFF});
    send_idle_pct = 80;
    recv_idle_pct = 16;
    for (int i = 0; i < 20; i++) pending_vertices.push_back(rand_vertex());
    drain();

    for (int i = 0; i < NREG; i++) write_reg(i, rand_pair());
    for (int i = 0; i < 100; i++) pending_vertices.push_back(rand_vertex());
    drain();

    for (int i = 0; i < NREG; i++) write_reg(i, (i == 7) ? {rand_q(), 32'h0} : rand_pair());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_cycles = 300;
    for (int i = 0; i < 150; i++) pending_vertices.push_back(rand_vertex());
    drain();

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/hmt_pkg.sv
hw/rtl/hmt_dot.sv
hw/rtl/hmt_prep.sv
hw/rtl/hmt_div.sv
hw/rtl/hmt_outq.sv
hw/rtl/homogeneous_matrix_transform.sv
hw/rtl/hmt_checker.sv
test/tb.sv
